>>> sv/pdfsm_pkg.sv
// pdfsm_pkg: shared types and constants for the presence debounce block
// used by pdfsm_cfg, pdfsm_core and presence_debounce_fsm; no dependencies
`default_nettype none

package pdfsm_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE     = CFG_IDX_W'(3);

    // register reset values and clamp floors
    localparam logic [31:0] ENTER_RESET     = 32'd500;
    localparam logic [31:0] EXIT_RESET      = 32'd500;
    localparam logic [31:0] HEARTBEAT_RESET = 32'd1000;
    localparam logic [31:0] LEASE_RESET     = 32'd2000;
    localparam logic [31:0] ENTER_MIN       = 32'd500;
    localparam logic [31:0] HEARTBEAT_MIN   = 32'd1000;
    localparam logic [31:0] LEASE_MARGIN    = 32'd1000;

    // presence state codes as seen on the result word
    localparam logic [2:0] PS_UNAVAIL = 3'd0;
    localparam logic [2:0] PS_WATCH   = 3'd1;
    localparam logic [2:0] PS_PPEND   = 3'd2;
    localparam logic [2:0] PS_PRESENT = 3'd3;
    localparam logic [2:0] PS_APEND   = 3'd4;

    // fact codes
    localparam logic [1:0] FACT_NONE    = 2'd0;
    localparam logic [1:0] FACT_PRESENT = 2'd1;
    localparam logic [1:0] FACT_ABSENT  = 2'd2;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_STOP   = 1'b1;

    // one-hot machine state
    typedef enum logic [4:0] {
        ST_UNAVAIL = 5'b00001,
        ST_WATCH   = 5'b00010,
        ST_PPEND   = 5'b00100,
        ST_PRESENT = 5'b01000,
        ST_APEND   = 5'b10000
    } state_t;

    // effective (clamped) timing values
    typedef struct packed {
        logic [31:0] enter;
        logic [31:0] exit_hold;
        logic [31:0] heartbeat;
        logic [31:0] lease;
    } cfg_eff_t;

    // one input word
    typedef struct packed {
        logic        cmd;
        logic [63:0] now_ms;
        logic        profile_on;
        logic [31:0] profile_rev;
        logic        face_hit;
        logic        face_ran;
        logic        body_ran;
        logic        body_seen;
    } item_t;

    // one result word
    typedef struct packed {
        logic [2:0]  presence_state;
        logic [1:0]  fact;
        logic [31:0] cur_revision;
        logic [31:0] fact_revision;
        logic [31:0] epoch_count;
        logic [31:0] fact_sequence;
        logic [63:0] time_echo;
        logic [63:0] last_match_time;
        logic [31:0] lease_out;
        logic        session_active;
    } result_t;

    // one-hot state to external code
    function automatic logic [2:0] state_code(input state_t st);
        logic [2:0] code;
        unique case (st)
            ST_UNAVAIL: code = PS_UNAVAIL;
            ST_WATCH:   code = PS_WATCH;
            ST_PPEND:   code = PS_PPEND;
            ST_PRESENT: code = PS_PRESENT;
            ST_APEND:   code = PS_APEND;
            default:    code = PS_UNAVAIL;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> sv/pdfsm_cfg.sv
// pdfsm_cfg: configuration registers and clamping of the timing values
// depends on pdfsm_pkg
`default_nettype none

module pdfsm_cfg
    import pdfsm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output cfg_eff_t                  eff
);

    logic [31:0] enter_reg;
    logic [31:0] exit_reg;
    logic [31:0] heartbeat_reg;
    logic [31:0] lease_reg;
    logic [31:0] enter_eff;
    logic [31:0] heartbeat_eff;
    logic [32:0] lease_floor_sum;
    logic [31:0] lease_floor;

    // always able to take a write
    assign cfg_ready = 1'b1;

    // register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_reg     <= ENTER_RESET;
            exit_reg      <= EXIT_RESET;
            heartbeat_reg <= HEARTBEAT_RESET;
            lease_reg     <= LEASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTER:     enter_reg     <= cfg_data;
                CFG_EXIT:      exit_reg      <= cfg_data;
                CFG_HEARTBEAT: heartbeat_reg <= cfg_data;
                CFG_LEASE:     lease_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // clamps; lease floor saturates at all ones
    assign enter_eff       = (enter_reg < ENTER_MIN) ? ENTER_MIN : enter_reg;
    assign heartbeat_eff   = (heartbeat_reg < HEARTBEAT_MIN) ? HEARTBEAT_MIN : heartbeat_reg;
    assign lease_floor_sum = {1'b0, heartbeat_eff} + {1'b0, LEASE_MARGIN};
    assign lease_floor     = lease_floor_sum[32] ? 32'hFFFF_FFFF : lease_floor_sum[31:0];

    assign eff.enter     = enter_eff;
    assign eff.exit_hold = (exit_reg < enter_eff) ? enter_eff : exit_reg;
    assign eff.heartbeat = heartbeat_eff;
    assign eff.lease     = (lease_reg < lease_floor) ? lease_floor : lease_reg;

endmodule

`default_nettype wire

>>> sv/pdfsm_core.sv
// pdfsm_core: presence state machine, timers, counters and result forming
// depends on pdfsm_pkg; takes clamped timing values from pdfsm_cfg
`default_nettype none

module pdfsm_core
    import pdfsm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire item_t    item,
    input  wire cfg_eff_t eff,
    output result_t       res
);

    state_t      st_reg,     st_next;
    logic [31:0] trev_reg,   trev_next;
    logic [63:0] pstart_reg, pstart_next;
    logic [63:0] lmatch_reg, lmatch_next;
    logic [63:0] lfact_reg,  lfact_next;
    logic        sess_reg,   sess_next;
    logic [31:0] epoch_reg,  epoch_next;
    logic [31:0] seq_reg,    seq_next;
    logic [1:0]  fact;
    logic [31:0] frev;

    // wrapping elapsed-time checks against the hold times
    logic [63:0] since_pend;
    logic [63:0] since_fact;
    logic [63:0] since_match;
    logic        enter_done;
    logic        beat_due;
    logic        exit_done;
    logic        mismatch;
    logic        observe;
    logic        identity;

    assign since_pend  = item.now_ms - pstart_reg;
    assign since_fact  = item.now_ms - lfact_reg;
    assign since_match = item.now_ms - lmatch_reg;
    assign enter_done  = since_pend  >= {32'd0, eff.enter};
    assign beat_due    = since_fact  >= {32'd0, eff.heartbeat};
    assign exit_done   = since_match >= {32'd0, eff.exit_hold};
    assign mismatch    = !item.profile_on || (item.profile_rev == 32'd0)
                         || (item.profile_rev != trev_reg);
    assign identity    = item.face_hit;
    assign observe     = item.face_hit
                         || (item.body_ran && item.body_seen && sess_reg);

    // next state for the word in the input register
    always_comb
    begin
        st_next     = st_reg;
        trev_next   = trev_reg;
        pstart_next = pstart_reg;
        lmatch_next = lmatch_reg;
        lfact_next  = lfact_reg;
        sess_next   = sess_reg;
        epoch_next  = epoch_reg;
        fact        = FACT_NONE;
        frev        = 32'd0;

        priority if (item.cmd == CMD_STOP || mismatch)
        begin
            // stop or profile change: drop everything
            if (st_reg == ST_PRESENT || st_reg == ST_APEND)
            begin
                fact = FACT_ABSENT;
                frev = trev_reg;
            end
            if (item.cmd == CMD_STOP || !item.profile_on)
            begin
                st_next   = ST_UNAVAIL;
                trev_next = 32'd0;
            end
            else
            begin
                st_next   = ST_WATCH;
                trev_next = item.profile_rev;
            end
            pstart_next = 64'd0;
            lmatch_next = 64'd0;
            lfact_next  = 64'd0;
            sess_next   = 1'b0;
        end
        else if (observe)
        begin
            // owner evidence
            if (item.face_hit)
                sess_next = 1'b1;
            lmatch_next = item.now_ms;
            if (st_reg == ST_WATCH && identity)
            begin
                st_next     = ST_PPEND;
                pstart_next = item.now_ms;
            end
            else if (st_reg == ST_PPEND && enter_done)
            begin
                st_next    = ST_PRESENT;
                epoch_next = epoch_reg + 32'd1;
                lfact_next = item.now_ms;
                fact       = FACT_PRESENT;
                frev       = trev_reg;
            end
            else if (st_reg == ST_APEND)
            begin
                st_next = ST_PRESENT;
            end
            // heartbeat while present
            if (fact == FACT_NONE && st_next == ST_PRESENT && beat_due)
            begin
                lfact_next = item.now_ms;
                fact       = FACT_PRESENT;
                frev       = trev_reg;
            end
        end
        else if (item.face_ran || item.body_ran)
        begin
            // no owner evidence
            if (st_reg == ST_PPEND && item.body_ran && !item.body_seen)
            begin
                st_next     = ST_WATCH;
                pstart_next = 64'd0;
                sess_next   = 1'b0;
            end
            else if (st_reg == ST_PRESENT && item.body_ran && !item.body_seen)
            begin
                st_next = ST_APEND;
            end
            else if (st_reg == ST_APEND && exit_done)
            begin
                st_next     = ST_WATCH;
                pstart_next = 64'd0;
                lfact_next  = 64'd0;
                sess_next   = 1'b0;
                fact        = FACT_ABSENT;
                frev        = trev_reg;
            end
        end
        else
        begin
            // no detector ran: everything holds
        end
    end

    assign seq_next = (fact != FACT_NONE) ? seq_reg + 32'd1 : seq_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_UNAVAIL;
            trev_reg   <= 32'd0;
            pstart_reg <= 64'd0;
            lmatch_reg <= 64'd0;
            lfact_reg  <= 64'd0;
            sess_reg   <= 1'b0;
            epoch_reg  <= 32'd0;
            seq_reg    <= 32'd0;
        end
        else if (step)
        begin
            st_reg     <= st_next;
            trev_reg   <= trev_next;
            pstart_reg <= pstart_next;
            lmatch_reg <= lmatch_next;
            lfact_reg  <= lfact_next;
            sess_reg   <= sess_next;
            epoch_reg  <= epoch_next;
            seq_reg    <= seq_next;
        end
    end

    // result word
    assign res.presence_state  = state_code(st_next);
    assign res.fact            = fact;
    assign res.cur_revision    = trev_next;
    assign res.fact_revision   = frev;
    assign res.epoch_count     = epoch_next;
    assign res.fact_sequence   = seq_next;
    assign res.time_echo       = item.now_ms;
    assign res.last_match_time = lmatch_next;
    assign res.lease_out       = (fact == FACT_PRESENT) ? eff.lease : 32'd0;
    assign res.session_active  = sess_next;

    // epoch only moves on entry into present, by one
    a_epoch_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (epoch_reg == $past(epoch_reg))
                 || (epoch_reg == $past(epoch_reg) + 32'd1 && st_reg == ST_PRESENT))
        else $error("epoch count moved without entry into present");

    // sequence count follows the facts emitted
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> seq_reg == $past(seq_reg) + (($past(fact) != FACT_NONE) ? 32'd1 : 32'd0))
        else $error("fact sequence does not match emitted facts");

    // nothing moves without a word
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(st_reg) && $stable(seq_reg) && $stable(trev_reg))
        else $error("state changed with no word processed");

endmodule

`default_nettype wire

>>> sv/presence_debounce_fsm.sv
// presence_debounce_fsm: top level with input register, result register and handshake
// depends on pdfsm_pkg, pdfsm_cfg and pdfsm_core
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per sample or stop
//   event; output channel (out_valid / out_stall) returns exactly one result
//   word per input word, in order. Configuration writes go through
//   cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high, indexes beyond 3 are ignored. Write configuration only while idle.
//   A word accepted into the input register has its result loaded into the
//   result register when that register is free. Throughput: one word per
//   cycle while the receiver does not stall; the state update is combinational
//   compares and 64-bit subtracts between the input and result registers.
//   Reset (rst_n low, asynchronous) puts the machine in unavailable, clears
//   revision, times, session, epoch and sequence, and loads the default
//   timing values 500 / 500 / 1000 / 2000 ms.
//   When the receiver stalls, the result register holds; one more word can
//   still be taken into the input register, after which in_stall rises until
//   the result is taken.
`default_nettype none

module presence_debounce_fsm
    import pdfsm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    // input words
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [63:0]          now_ms,
    input  wire logic                 profile_on,
    input  wire logic [31:0]          profile_rev,
    input  wire logic                 face_hit,
    input  wire logic                 face_ran,
    input  wire logic                 body_ran,
    input  wire logic                 body_seen,
    // result words
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                presence_state,
    output logic [1:0]                fact,
    output logic [31:0]               cur_revision,
    output logic [31:0]               fact_revision,
    output logic [31:0]               epoch_count,
    output logic [31:0]               fact_sequence,
    output logic [63:0]               time_echo,
    output logic [63:0]               last_match_time,
    output logic [31:0]               lease_out,
    output logic                      session_active
);

    cfg_eff_t eff;
    item_t    item_reg;
    logic     in_vld_reg, in_vld_next;
    result_t  res_comb;
    result_t  res_reg;
    logic     out_vld_reg, out_vld_next;
    logic     out_load;
    logic     step;
    logic     in_take;

    // configuration registers
    pdfsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    // handshake control
    assign out_load     = !out_vld_reg || !out_stall;
    assign step         = in_vld_reg && out_load;
    assign in_stall     = in_vld_reg && !out_load;
    assign in_take      = in_valid && !in_stall;
    assign in_vld_next  = in_take || (in_vld_reg && !step);
    assign out_vld_next = step || (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd         <= cmd;
            item_reg.now_ms      <= now_ms;
            item_reg.profile_on  <= profile_on;
            item_reg.profile_rev <= profile_rev;
            item_reg.face_hit    <= face_hit;
            item_reg.face_ran    <= face_ran;
            item_reg.body_ran    <= body_ran;
            item_reg.body_seen   <= body_seen;
        end
    end

    // state machine
    pdfsm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .eff   (eff),
        .res   (res_comb)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_comb;
    end

    assign out_valid       = out_vld_reg;
    assign presence_state  = res_reg.presence_state;
    assign fact            = res_reg.fact;
    assign cur_revision    = res_reg.cur_revision;
    assign fact_revision   = res_reg.fact_revision;
    assign epoch_count     = res_reg.epoch_count;
    assign fact_sequence   = res_reg.fact_sequence;
    assign time_echo       = res_reg.time_echo;
    assign last_match_time = res_reg.last_match_time;
    assign lease_out       = res_reg.lease_out;
    assign session_active  = res_reg.session_active;

    // a present fact only comes out of the present state, with a lease
    a_present_fact: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fact == FACT_PRESENT) |->
            (presence_state == PS_PRESENT && lease_out != 32'd0))
        else $error("present fact outside present state or without lease");

    // no fact, no revision and no lease
    a_no_fact: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fact == FACT_NONE) |-> (fact_revision == 32'd0 && lease_out == 32'd0))
        else $error("revision or lease reported without a fact");

    // unavailable means nothing is tracked
    a_unavail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && presence_state == PS_UNAVAIL) |->
            (cur_revision == 32'd0 && !session_active && last_match_time == 64'd0))
        else $error("unavailable state with tracked profile data");

endmodule

`default_nettype wire

>>> test/tb_presence_debounce_fsm.sv
`timescale 1ns / 1ps
// tb_presence_debounce_fsm: self-checking bench for the presence debounce block
// drives stimulus words, predicts every result word and compares field by field
// depends on pdfsm_pkg and presence_debounce_fsm

module tb_presence_debounce_fsm;
    import pdfsm_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          WORDS_PER_SET = 135;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [31:0] REV_A         = 32'hFFFF_FFFF;
    localparam logic [31:0] REV_B         = 32'd7;
    // heartbeat values on either side of the lease saturation point
    localparam logic [31:0] BEAT_SAT      = 32'hFFFF_FC18;
    localparam logic [31:0] BEAT_EDGE     = 32'hFFFF_FC17;

    // one directed stimulus row, optionally with a typed-in state and fact
    typedef struct {
        item_t      word;
        bit         pinned;
        logic [2:0] want_state;
        logic [1:0] want_fact;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 cmd = CMD_SAMPLE;
    logic [63:0]          now_ms = '0;
    logic                 profile_on = 1'b0;
    logic [31:0]          profile_rev = '0;
    logic                 face_hit = 1'b0;
    logic                 face_ran = 1'b0;
    logic                 body_ran = 1'b0;
    logic                 body_seen = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           presence_state;
    logic [1:0]           fact;
    logic [31:0]          cur_revision;
    logic [31:0]          fact_revision;
    logic [31:0]          epoch_count;
    logic [31:0]          fact_sequence;
    logic [63:0]          time_echo;
    logic [63:0]          last_match_time;
    logic [31:0]          lease_out;
    logic                 session_active;

    // raw timing registers as last written
    logic [31:0] raw_enter = ENTER_RESET;
    logic [31:0] raw_exit  = EXIT_RESET;
    logic [31:0] raw_beat  = HEARTBEAT_RESET;
    logic [31:0] raw_lease = LEASE_RESET;

    // predicted machine state
    logic [2:0]  pm_state   = PS_UNAVAIL;
    logic [31:0] pm_rev     = '0;
    logic [63:0] pm_pend    = '0;
    logic [63:0] pm_match   = '0;
    logic [63:0] pm_beat    = '0;
    logic        pm_session = 1'b0;
    logic [31:0] pm_epoch   = '0;
    logic [31:0] pm_seq     = '0;

    result_t  expected_results[$];
    dir_row_t dir_rows[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       burst_left = 1;
    logic [63:0] clock_ms = '0;
    logic [31:0] owner_rev = REV_A;

    presence_debounce_fsm dut (.*);

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // clamped timing values from the raw registers
    function automatic cfg_eff_t clamp_timing();
        cfg_eff_t e;
        logic [31:0] lease_floor;
        e.enter     = (raw_enter < ENTER_MIN) ? ENTER_MIN : raw_enter;
        e.exit_hold = (raw_exit < e.enter) ? e.enter : raw_exit;
        e.heartbeat = (raw_beat < HEARTBEAT_MIN) ? HEARTBEAT_MIN : raw_beat;
        lease_floor = (e.heartbeat > 32'hFFFF_FFFF - LEASE_MARGIN) ? 32'hFFFF_FFFF
                                                                   : e.heartbeat + LEASE_MARGIN;
        e.lease     = (raw_lease < lease_floor) ? lease_floor : raw_lease;
        return e;
    endfunction

    // advance the debounce machine by one word and build its result
    function automatic result_t predict_presence(item_t w);
        result_t     r;
        cfg_eff_t    e;
        logic [1:0]  f;
        logic [31:0] frev;
        logic        had_presence;
        e = clamp_timing();
        f = FACT_NONE;
        frev = '0;
        if (w.cmd == CMD_STOP || !w.profile_on || w.profile_rev == '0
            || w.profile_rev != pm_rev)
        begin
            // stop or profile change: drop everything
            had_presence = (pm_state == PS_PRESENT || pm_state == PS_APEND);
            frev = pm_rev;
            if (w.cmd == CMD_STOP || !w.profile_on)
            begin
                pm_state = PS_UNAVAIL;
                pm_rev = '0;
            end
            else
            begin
                pm_state = PS_WATCH;
                pm_rev = w.profile_rev;
            end
            pm_pend = '0;
            pm_match = '0;
            pm_beat = '0;
            pm_session = 1'b0;
            if (had_presence)
                f = FACT_ABSENT;
        end
        else if (w.face_hit || (w.body_ran && w.body_seen && pm_session))
        begin
            // owner evidence, face or person inside an open session
            if (w.face_hit)
                pm_session = 1'b1;
            pm_match = w.now_ms;
            if (pm_state == PS_WATCH && w.face_hit)
            begin
                pm_state = PS_PPEND;
                pm_pend = w.now_ms;
            end
            else if (pm_state == PS_PPEND && w.now_ms - pm_pend >= 64'(e.enter))
            begin
                pm_state = PS_PRESENT;
                pm_epoch++;
                pm_beat = w.now_ms;
                f = FACT_PRESENT;
            end
            else if (pm_state == PS_APEND)
                pm_state = PS_PRESENT;
            if (f == FACT_NONE && pm_state == PS_PRESENT
                && w.now_ms - pm_beat >= 64'(e.heartbeat))
            begin
                pm_beat = w.now_ms;
                f = FACT_PRESENT;
            end
            frev = pm_rev;
        end
        else if (w.face_ran || w.body_ran)
        begin
            // no evidence from a detector that ran
            if (pm_state == PS_PPEND && w.body_ran && !w.body_seen)
            begin
                pm_state = PS_WATCH;
                pm_pend = '0;
                pm_session = 1'b0;
            end
            else if (pm_state == PS_PRESENT && w.body_ran && !w.body_seen)
                pm_state = PS_APEND;
            else if (pm_state == PS_APEND && w.now_ms - pm_match >= 64'(e.exit_hold))
            begin
                pm_state = PS_WATCH;
                pm_pend = '0;
                pm_beat = '0;
                pm_session = 1'b0;
                f = FACT_ABSENT;
                frev = pm_rev;
            end
        end
        if (f != FACT_NONE)
            pm_seq++;
        r.presence_state  = pm_state;
        r.fact            = f;
        r.cur_revision    = pm_rev;
        r.fact_revision   = (f != FACT_NONE) ? frev : '0;
        r.epoch_count     = pm_epoch;
        r.fact_sequence   = pm_seq;
        r.time_echo       = w.now_ms;
        r.last_match_time = pm_match;
        r.lease_out       = (f == FACT_PRESENT) ? e.lease : '0;
        r.session_active  = pm_session;
        return r;
    endfunction

    function automatic dir_row_t row(input logic c, input logic [63:0] t, input logic act,
                                     input logic [31:0] rv, input logic fm, input logic fe,
                                     input logic pe, input logic pp, input bit pin = 1'b0,
                                     input logic [2:0] st = PS_UNAVAIL,
                                     input logic [1:0] fc = FACT_NONE);
        dir_row_t d;
        d.word = '{cmd: c, now_ms: t, profile_on: act, profile_rev: rv, face_hit: fm,
                   face_ran: fe, body_ran: pe, body_seen: pp};
        d.pinned = pin;
        d.want_state = st;
        d.want_fact = fc;
        return d;
    endfunction

    // random word: mostly well-formed owner sequences, some stops and profile churn
    function automatic item_t random_word();
        item_t       w;
        cfg_eff_t    e;
        logic [63:0] span;
        int          pick;
        e = clamp_timing();
        span = 64'(e.enter);
        if (64'(e.exit_hold) > span)
            span = 64'(e.exit_hold);
        if (64'(e.heartbeat) > span)
            span = 64'(e.heartbeat);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            clock_ms += span * $urandom_range(0, 60) / 100;
        else if (pick < 88)
            clock_ms += span * $urandom_range(60, 160) / 100;
        else if (pick < 92)
            clock_ms += span;
        else if (pick < 97)
            clock_ms += 0;
        else
            clock_ms += {$urandom, $urandom};
        w.cmd         = CMD_SAMPLE;
        w.now_ms      = clock_ms;
        w.profile_on  = 1'b1;
        w.profile_rev = owner_rev;
        w.face_hit    = ($urandom_range(0, 99) < 30);
        w.face_ran    = ($urandom_range(0, 99) < 70);
        w.body_ran    = ($urandom_range(0, 99) < 60);
        w.body_seen   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 999);
        if (pick < 15)
        begin
            w.cmd = CMD_STOP;
            w.profile_on = 1'($urandom_range(0, 1));
            w.profile_rev = $urandom;
        end
        else if (pick < 30)
        begin
            w.profile_on = 1'b0;
            w.profile_rev = $urandom;
        end
        else if (pick < 45)
        begin
            owner_rev = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
            w.profile_rev = owner_rev;
        end
        return w;
    endfunction

    // present one word and wait until it is taken
    task automatic offer(input item_t w, input bit pinned = 1'b0,
                         input logic [2:0] want_st = PS_UNAVAIL,
                         input logic [1:0] want_fc = FACT_NONE);
        result_t r;
        in_valid    <= 1'b1;
        cmd         <= w.cmd;
        now_ms      <= w.now_ms;
        profile_on  <= w.profile_on;
        profile_rev <= w.profile_rev;
        face_hit    <= w.face_hit;
        face_ran    <= w.face_ran;
        body_ran    <= w.body_ran;
        body_seen   <= w.body_seen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_presence(w);
        if (pinned)
        begin
            r.presence_state = want_st;
            r.fact = want_fc;
        end
        expected_results.push_back(r);
    endtask

    // bursts of random length with random gaps
    task automatic pause_sender(input bit last);
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && !last)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ENTER:     raw_enter = data;
            CFG_EXIT:      raw_exit = data;
            CFG_HEARTBEAT: raw_beat = data;
            CFG_LEASE:     raw_lease = data;
            default:       ;
        endcase
    endtask

    task automatic set_timing(input logic [31:0] enter_v, input logic [31:0] exit_v,
                              input logic [31:0] beat_v, input logic [31:0] lease_v);
        write_reg(CFG_ENTER, enter_v);
        write_reg(CFG_EXIT, exit_v);
        write_reg(CFG_HEARTBEAT, beat_v);
        write_reg(CFG_LEASE, lease_v);
        // out-of-range index must leave the timing alone
        write_reg(CFG_IDX_W'($urandom_range(CFG_LEASE + 1, 2 ** CFG_IDX_W - 1)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: check each result word, then choose the stall for the next cycle
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int words_taken = 0;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word, time_echo expected none got %h",
                         $time, time_echo);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("presence_state", 64'(want.presence_state), 64'(presence_state));
                check_field("fact", 64'(want.fact), 64'(fact));
                check_field("cur_revision", 64'(want.cur_revision), 64'(cur_revision));
                check_field("fact_revision", 64'(want.fact_revision), 64'(fact_revision));
                check_field("epoch_count", 64'(want.epoch_count), 64'(epoch_count));
                check_field("fact_sequence", 64'(want.fact_sequence), 64'(fact_sequence));
                check_field("time_echo", want.time_echo, time_echo);
                check_field("last_match_time", want.last_match_time, last_match_time);
                check_field("lease_out", 64'(want.lease_out), 64'(lease_out));
                check_field("session_active", 64'(want.session_active), 64'(session_active));
            end
            words_taken++;
            // long hold-off so the block fills and stalls its input
            if (words_taken % 250 == 50)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk at reset timing; flag order is face match, face eval,
        // person eval, person present
        dir_rows.push_back(row(CMD_STOP, 64'd0, 0, 32'd0, 0, 0, 0, 0, 1, PS_UNAVAIL, FACT_NONE));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd0, 0, 32'd5, 1, 1, 1, 1,
                               1, PS_UNAVAIL, FACT_NONE));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd10, 1, 32'd0, 0, 0, 0, 0,
                               1, PS_WATCH, FACT_NONE));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd20, 1, REV_A, 0, 0, 0, 0,
                               1, PS_WATCH, FACT_NONE));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd100, 1, REV_A, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd200, 1, REV_A, 1, 1, 0, 0,
                               1, PS_PPEND, FACT_NONE));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd600, 1, REV_A, 1, 1, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd700, 1, REV_A, 1, 1, 0, 0,
                               1, PS_PRESENT, FACT_PRESENT));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd1200, 1, REV_A, 0, 0, 1, 1));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd1700, 1, REV_A, 1, 1, 1, 1,
                               1, PS_PRESENT, FACT_PRESENT));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd1800, 1, REV_A, 0, 1, 1, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd2000, 1, REV_A, 0, 1, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd2200, 1, REV_A, 0, 1, 0, 0,
                               1, PS_WATCH, FACT_ABSENT));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd2300, 1, REV_A, 1, 1, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd2400, 1, REV_A, 0, 0, 1, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd2500, 1, REV_A, 1, 0, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd3000, 1, REV_A, 1, 1, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd3100, 1, REV_B, 0, 0, 0, 0,
                               1, PS_WATCH, FACT_ABSENT));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd3200, 1, REV_B, 1, 1, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd3700, 1, REV_B, 1, 1, 0, 0));
        dir_rows.push_back(row(CMD_SAMPLE, 64'd3800, 1, REV_B, 0, 0, 1, 0));
        dir_rows.push_back(row(CMD_STOP, 64'hFFFF_FFFF_FFFF_FFFF, 1, REV_B, 1, 1, 1, 1,
                               1, PS_UNAVAIL, FACT_ABSENT));
        dir_rows.push_back(row(CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 0, REV_A, 1, 1, 1, 1,
                               1, PS_UNAVAIL, FACT_NONE));
        foreach (dir_rows[i])
        begin
            offer(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].want_state,
                  dir_rows[i].want_fact);
            pause_sender(i == dir_rows.size() - 1);
        end
        in_valid <= 1'b0;
        drain();

        // random sets over several timing settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_timing('0, '0, '0, '0);
                1: set_timing($urandom_range(0, 3000), $urandom_range(0, 6000),
                              $urandom_range(0, 4000), $urandom_range(0, 9000));
                2: set_timing('1, '0, '1, '0);
                3: set_timing(32'd600, '1, BEAT_SAT, $urandom);
                4: set_timing(ENTER_MIN, EXIT_RESET, BEAT_EDGE, 32'd5);
                default: set_timing(ENTER_RESET, EXIT_RESET, HEARTBEAT_RESET, LEASE_RESET);
            endcase
            // first set starts just short of the timestamp wrap
            clock_ms = (p == 0) ? 64'hFFFF_FFFF_FFFF_F000 : {$urandom, $urandom};
            for (int n = 0; n < WORDS_PER_SET; n++)
            begin
                offer(random_word());
                pause_sender(n == WORDS_PER_SET - 1);
            end
            in_valid <= 1'b0;
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> presence_debounce_fsm.f
sv/pdfsm_pkg.sv
sv/pdfsm_cfg.sv
sv/pdfsm_core.sv
sv/presence_debounce_fsm.sv
test/tb_presence_debounce_fsm.sv
